FILE: src/tvr_pkg.sv
// ----------------------------------------------------------------------------
// tvr_pkg: shared constants for the tv regularized pixel update
// fixed-point formats and pipeline depth helpers used by all modules
// ----------------------------------------------------------------------------
package tvr_pkg;

	// fraction bits of a normalized contribution (q1.16)
	localparam int CFRAC = 16;
	// signed contribution in [-1, 1]
	localparam int CONTRIB_W = CFRAC + 2;
	// divergence, x and y differences of the four contributions
	localparam int DIVG_W = CFRAC + 4;
	// regularization weight, unsigned q0.16
	localparam int LAMBDA_W = 16;
	// lambda * divergence, signed
	localparam int PROD_W = LAMBDA_W + 1 + DIVG_W;
	// position of one in the denominator (q.32)
	localparam int ONE_SHIFT = 32;
	// signed denominator
	localparam int DENS_W = PROD_W + 1;
	// magnitude of a positive denominator
	localparam int DEN_W = ONE_SHIFT + 3;
	// partial remainder of the final divide
	localparam int REM_W = DEN_W + 1;

	// difference magnitude bits after dropping low bits of wide pixels
	function automatic int mag_width(input int pw);
		return (pw > 16) ? 16 : pw;
	endfunction

	// register stages from an input word to a registered contribution
	function automatic int contrib_latency(input int pw);
		return mag_width(pw) + 21;
	endfunction

endpackage

FILE: src/tvr_if.sv
// ----------------------------------------------------------------------------
// tvr_if: streaming channels of the tv regularized pixel update
// input word carries the pixel and its neighborhood, output word the result
// ----------------------------------------------------------------------------
interface tvr_in_if #(parameter int PIXEL_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [PIXEL_WIDTH-1:0] new_value;
	logic [PIXEL_WIDTH-1:0] last_center;
	logic [PIXEL_WIDTH-1:0] last_left;
	logic [PIXEL_WIDTH-1:0] last_left_far;
	logic [PIXEL_WIDTH-1:0] last_right;
	logic [PIXEL_WIDTH-1:0] last_up;
	logic [PIXEL_WIDTH-1:0] last_up_far;
	logic [PIXEL_WIDTH-1:0] last_down;
	logic                   interior;

	modport source (
		output valid, new_value, last_center, last_left, last_left_far,
		output last_right, last_up, last_up_far, last_down, interior,
		input  ready
	);
	modport sink (
		input  valid, new_value, last_center, last_left, last_left_far,
		input  last_right, last_up, last_up_far, last_down, interior,
		output ready
	);
endinterface

interface tvr_out_if #(parameter int PIXEL_WIDTH = 16);
	logic                   valid;
	logic                   ready;
	logic [PIXEL_WIDTH-1:0] regularized_value;
	logic                   saturated;

	modport source (output valid, regularized_value, saturated, input ready);
	modport sink (input valid, regularized_value, saturated, output ready);
endinterface

FILE: src/tv_regularized_pixel_update.sv
// ----------------------------------------------------------------------------
// tv_regularized_pixel_update: total-variation correction of one pixel
// scales the new estimate by 1 / (1 - lambda * div) from a minmod-limited
// divergence of the previous estimate
// ----------------------------------------------------------------------------
// One word in and out per clock when not stalled. The fixed pipe has
// PIXEL_WIDTH + min(PIXEL_WIDTH, 16) + 26 register stages (58 at width 16):
// four parallel contribution pipes (square root and normalizing divide, one
// bit per stage each), divergence sum, lambda multiply, denominator, then a
// one-bit-per-stage divide of new_value * 2^32 by the denominator. The whole
// pipe advances whenever the output register is empty or being taken, so a
// stall on the output holds every stage in place. lambda is to be written
// through lambda_we / lambda_wdata only while no word is in flight; the block
// does not enforce it. Interior-low words take the same pipe and exit unchanged.
// ----------------------------------------------------------------------------
module tv_regularized_pixel_update import tvr_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                lambda_we,
	input  logic [LAMBDA_W-1:0] lambda_wdata,
	tvr_in_if.sink              pix_in,
	tvr_out_if.source           pix_out
);

	localparam int CL = contrib_latency(PIXEL_WIDTH);   // contribution pipes
	localparam int DL = PIXEL_WIDTH + 1;                 // final divider
	localparam int LT = CL + 3 + DL + 1;                 // whole pipe
	localparam logic [PIXEL_WIDTH-1:0] PIX_MAX = '1;

	// per-word control carried alongside the final divider
	typedef struct packed {
		logic [PIXEL_WIDTH-1:0] nv;
		logic                   interior;
		logic                   den_pos;
		logic                   den_zero;
	} tail_t;

	logic                 advance;
	logic [LAMBDA_W-1:0]  lambda_q;
	logic                 vld_q [1:LT];

	// neighborhood differences, one bit wider and signed
	logic signed [PIXEL_WIDTH:0] d_rc, d_cl, d_lll, d_dc, d_cu, d_uuu;
	logic signed [CONTRIB_W-1:0] cx1, cx0, cy1, cy0;

	logic [PIXEL_WIDTH-1:0] nv_p  [1:CL];
	logic                   int_p [1:CL];

	logic signed [DIVG_W-1:0] divg_d1;
	logic [PIXEL_WIDTH-1:0]   nv_d1, nv_d2, nv_d3;
	logic                     int_d1, int_d2, int_d3;
	logic signed [PROD_W-1:0] prod_d2;
	logic signed [DENS_W-1:0] den_c;
	logic [DEN_W-1:0]         den_d3;
	logic                     den_pos_d3, den_zero_d3;

	tail_t                  tail_p [1:DL];
	logic [PIXEL_WIDTH-1:0] quot;
	logic                   ovf;

	logic [PIXEL_WIDTH-1:0] res_value;
	logic                   res_sat;

	// a single stall signal for every stage
	assign advance      = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
		end else if (lambda_we) begin
			lambda_q <= lambda_wdata;
		end
	end

	// valid bits, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LT; i++) vld_q[i] <= 1'b0;
		end else if (advance) begin
			vld_q[1] <= pix_in.valid;
			for (int i = 2; i <= LT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// forward differences in x and y
	assign d_rc  = signed'({1'b0, pix_in.last_right})  - signed'({1'b0, pix_in.last_center});
	assign d_cl  = signed'({1'b0, pix_in.last_center}) - signed'({1'b0, pix_in.last_left});
	assign d_lll = signed'({1'b0, pix_in.last_left})   - signed'({1'b0, pix_in.last_left_far});
	assign d_dc  = signed'({1'b0, pix_in.last_down})   - signed'({1'b0, pix_in.last_center});
	assign d_cu  = signed'({1'b0, pix_in.last_center}) - signed'({1'b0, pix_in.last_up});
	assign d_uuu = signed'({1'b0, pix_in.last_up})     - signed'({1'b0, pix_in.last_up_far});

	// four normalized contributions, each limited by the difference behind it
	tvr_contrib #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_cx1 (
		.clk(clk), .en(advance), .dp(d_rc), .dm(d_cl), .contrib(cx1)
	);
	tvr_contrib #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_cx0 (
		.clk(clk), .en(advance), .dp(d_cl), .dm(d_lll), .contrib(cx0)
	);
	tvr_contrib #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_cy1 (
		.clk(clk), .en(advance), .dp(d_dc), .dm(d_cu), .contrib(cy1)
	);
	tvr_contrib #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_cy0 (
		.clk(clk), .en(advance), .dp(d_cu), .dm(d_uuu), .contrib(cy0)
	);

	// pixel and interior flag ride along with the contribution pipes
	always_ff @(posedge clk) begin
		if (advance) begin
			nv_p[1]  <= pix_in.new_value;
			int_p[1] <= pix_in.interior;
			for (int i = 2; i <= CL; i++) begin
				nv_p[i]  <= nv_p[i-1];
				int_p[i] <= int_p[i-1];
			end
		end
	end

	// divergence, lambda product, denominator
	assign den_c = (DENS_W'(1) <<< ONE_SHIFT) - DENS_W'(prod_d2);

	always_ff @(posedge clk) begin
		if (advance) begin
			divg_d1     <= DIVG_W'(cx1) - DIVG_W'(cx0) + DIVG_W'(cy1) - DIVG_W'(cy0);
			nv_d1       <= nv_p[CL];
			int_d1      <= int_p[CL];
			prod_d2     <= signed'({1'b0, lambda_q}) * divg_d1;
			nv_d2       <= nv_d1;
			int_d2      <= int_d1;
			den_d3      <= den_c[DEN_W-1:0];
			den_pos_d3  <= !den_c[DENS_W-1] && (den_c != '0);
			den_zero_d3 <= den_c == '0;
			nv_d3       <= nv_d2;
			int_d3      <= int_d2;
		end
	end

	// new_value * 2^32 / den
	tvr_scale_div #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_div (
		.clk(clk), .en(advance), .den(den_d3), .nv(nv_d3), .quot(quot), .ovf(ovf)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			tail_p[1] <= '{nv: nv_d3, interior: int_d3, den_pos: den_pos_d3,
				den_zero: den_zero_d3};
			for (int i = 2; i <= DL; i++) tail_p[i] <= tail_p[i-1];
		end
	end

	// result select: pass-through, quotient, clamp, or zero
	always_comb begin
		res_value = tail_p[DL].nv;
		res_sat   = 1'b0;
		if (tail_p[DL].interior) begin
			if (tail_p[DL].den_pos) begin
				if (ovf) begin
					res_value = PIX_MAX;
					res_sat   = 1'b1;
				end else begin
					res_value = quot;
				end
			end else if (tail_p[DL].den_zero && (tail_p[DL].nv != '0)) begin
				res_value = PIX_MAX;
				res_sat   = 1'b1;
			end else begin
				res_value = '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance) begin
			pix_out.regularized_value <= res_value;
			pix_out.saturated         <= res_sat;
		end
	end

	assign pix_out.valid = vld_q[LT];

endmodule

FILE: src/tvr_contrib.sv
// ----------------------------------------------------------------------------
// tvr_contrib: one normalized, minmod-limited forward difference
// pipelined square root (one result bit a stage) then a one-bit-a-stage divide
// ----------------------------------------------------------------------------
module tvr_contrib import tvr_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [PIXEL_WIDTH:0] dp,
	input  logic signed [PIXEL_WIDTH:0] dm,
	output logic signed [CONTRIB_W-1:0] contrib
);

	localparam int AW  = mag_width(PIXEL_WIDTH);
	localparam int SH  = PIXEL_WIDTH - AW;
	localparam int SW  = 2 * AW + 1;
	localparam int RW  = AW + 1;
	localparam int NSQ = AW + 1;
	localparam int QW  = CFRAC + 1;

	logic                 pneg, mneg;
	logic [PIXEL_WIDTH:0] dp_abs, dm_abs;
	logic [AW-1:0]        ap, am, lim;

	logic [AW-1:0] ap_s1, lim_s1;
	logic          neg_s1;
	logic [SW-1:0] ap_w, lim_w;

	logic [SW-1:0] sq_v_s [0:NSQ];
	logic [SW-1:0] sq_r_s [0:NSQ];
	logic [AW-1:0] sq_a_s [0:NSQ];
	logic          sq_n_s [0:NSQ];

	logic [RW-1:0] dv_rem_s [0:QW];
	logic [RW-1:0] dv_r_s   [0:QW];
	logic [QW-1:0] dv_q_s   [0:QW];
	logic          dv_n_s   [0:QW];
	logic signed [CONTRIB_W-1:0] q_signed;

	// magnitudes and limiter; a zero difference counts as positive
	assign pneg   = dp[PIXEL_WIDTH];
	assign mneg   = dm[PIXEL_WIDTH];
	assign dp_abs = pneg ? (PIXEL_WIDTH+1)'(-dp) : (PIXEL_WIDTH+1)'(dp);
	assign dm_abs = mneg ? (PIXEL_WIDTH+1)'(-dm) : (PIXEL_WIDTH+1)'(dm);
	assign ap     = AW'(dp_abs[PIXEL_WIDTH-1:0] >> SH);
	assign am     = AW'(dm_abs[PIXEL_WIDTH-1:0] >> SH);
	assign lim    = (pneg == mneg) ? ((ap < am) ? ap : am) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s1  <= ap;
			lim_s1 <= lim;
			neg_s1 <= pneg;
		end
	end

	// sum of squares plus one lsb
	assign ap_w  = SW'(ap_s1);
	assign lim_w = SW'(lim_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0] <= ap_w * ap_w + lim_w * lim_w + SW'(1);
			sq_a_s[0] <= ap_s1;
			sq_n_s[0] <= neg_s1;
		end
	end
	assign sq_r_s[0] = '0;

	// integer square root, one result bit a stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [SW-1:0] BITK = SW'(1) << (2 * (AW - k));
		logic [SW:0] trial;
		assign trial = {1'b0, sq_r_s[k]} + {1'b0, BITK};
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, sq_v_s[k]} >= trial) begin
					sq_v_s[k+1] <= sq_v_s[k] - trial[SW-1:0];
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + BITK;
				end else begin
					sq_v_s[k+1] <= sq_v_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_a_s[k+1] <= sq_a_s[k];
				sq_n_s[k+1] <= sq_n_s[k];
			end
		end
	end

	// (ap << 16) / r; ap <= r so the quotient fits 17 bits
	assign dv_rem_s[0] = RW'(sq_a_s[NSQ] >> 1);
	assign dv_r_s[0]   = sq_r_s[NSQ][RW-1:0];
	assign dv_q_s[0]   = '0;
	assign dv_n_s[0]   = sq_n_s[NSQ];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic          bin;
		logic [RW:0]   t, diff;
		assign bin  = (j == 0) ? sq_a_s[NSQ][0] : 1'b0;
		assign t    = {dv_rem_s[j], bin};
		assign diff = t - {1'b0, dv_r_s[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, dv_r_s[j]}) begin
					dv_rem_s[j+1] <= diff[RW-1:0];
					dv_q_s[j+1]   <= {dv_q_s[j][QW-2:0], 1'b1};
				end else begin
					dv_rem_s[j+1] <= t[RW-1:0];
					dv_q_s[j+1]   <= {dv_q_s[j][QW-2:0], 1'b0};
				end
				dv_r_s[j+1] <= dv_r_s[j];
				dv_n_s[j+1] <= dv_n_s[j];
			end
		end
	end

	assign q_signed = signed'({1'b0, dv_q_s[QW]});

	always_ff @(posedge clk) begin
		if (en) begin
			contrib <= dv_n_s[QW] ? -q_signed : q_signed;
		end
	end

endmodule

FILE: src/tvr_scale_div.sv
// ----------------------------------------------------------------------------
// tvr_scale_div: pipelined restoring divide of new_value * 2^32 by den
// one quotient bit a stage, with an up-front overflow check
// ----------------------------------------------------------------------------
module tvr_scale_div import tvr_pkg::*; #(
	parameter int PIXEL_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [DEN_W-1:0]       den,
	input  logic [PIXEL_WIDTH-1:0] nv,
	output logic [PIXEL_WIDTH-1:0] quot,
	output logic                   ovf
);

	logic [REM_W-1:0]       rem_s [0:PIXEL_WIDTH];
	logic [DEN_W-1:0]       den_s [0:PIXEL_WIDTH];
	logic [PIXEL_WIDTH-1:0] q_s   [0:PIXEL_WIDTH];
	logic                   ovf_s [0:PIXEL_WIDTH];
	logic [REM_W-1:0]       rem0;

	// top of the dividend; at or above den the quotient needs more bits
	assign rem0 = REM_W'(nv) << (ONE_SHIFT - PIXEL_WIDTH);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0;
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= rem0 >= {1'b0, den};
		end
	end

	for (genvar k = 0; k < PIXEL_WIDTH; k++) begin : g_step
		logic [REM_W-1:0] t;
		assign t = rem_s[k] << 1;
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, den_s[k]}) begin
					rem_s[k+1] <= t - {1'b0, den_s[k]};
					q_s[k+1]   <= {q_s[k][PIXEL_WIDTH-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= t;
					q_s[k+1]   <= {q_s[k][PIXEL_WIDTH-2:0], 1'b0};
				end
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quot = q_s[PIXEL_WIDTH];
	assign ovf  = ovf_s[PIXEL_WIDTH];

endmodule
